[design/aifs_pkg.sv]
package aifs_pkg;

  // default depth of the digit store
  localparam int unsigned MaxDigitsDefault = 256;

  // configuration register indexes
  localparam logic [1:0] REG_BASE_MODE  = 2'd0;
  localparam logic [1:0] REG_MAX_WIDTH  = 2'd1;
  localparam logic [1:0] REG_OUT_SIZE   = 2'd2;
  localparam logic [1:0] REG_SIGNED_OUT = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_MATCH_FAIL = 2'd1;
  localparam logic [1:0] ST_INPUT_FAIL = 2'd2;

  // one input beat
  typedef struct packed {
    logic       at_end;
    logic [7:0] in_byte;
  } item_t;

  // one result beat
  typedef struct packed {
    logic [15:0] bytes_used;
    logic        pushed_back;
    logic [1:0]  status;
    logic [63:0] value;
  } res_t;

endpackage

[design/ascii_integer_field_scanner.sv]
// ASCII integer field scanner: one scanf-style integer conversion, fed a byte per beat.
// Input stream: tdata carries the text byte, tuser flags end of input (byte ignored).
// Output stream: one beat per finished field with the converted value, the status
// (ok, match failure, input failure), whether the last input byte was pushed back
// and must be sent again, and the bytes consumed by the field.
// Configuration: write base mode, max width, result size and signed extension
// through cfg_we_i / cfg_idx_i / cfg_data_i while the scanner is idle.
// Throughput: one input beat per cycle, but a byte that ends a field waits while the
// output queue is full; each digit byte takes one multiply-by-base accumulate, done by
// shifts and adds in the single processing stage. The beat that ends a field is taken
// into the input register, and its result is then registered into the output queue.
// Reset clears the field state, empties the queues and loads the register
// defaults (decimal, unlimited width, 32-bit result, sign-extended).
// When the receiver stalls, results wait in a two-entry output queue; bytes that
// do not end a field keep flowing, and a byte that ends a field waits only while
// that queue is full.
module ascii_integer_field_scanner #(
  parameter int unsigned MaxDigits = aifs_pkg::MaxDigitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  logic [0:0]  s_axis_tuser_i,   // [0] at_end
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o,   // [63:0] value, [79:64] bytes_used
  output logic [2:0]  m_axis_tuser_o    // [1:0] status, [2] pushed_back
);

  import aifs_pkg::*;

  item_t      item;
  res_t       res;
  res_t       head;
  logic       res_push;
  logic       res_full;
  logic [$bits(res_t)-1:0] head_bits;

  assign item.in_byte = s_axis_tdata_i;
  assign item.at_end  = s_axis_tuser_i[0];

  // conversion stage
  aifs_core #(
    .MaxDigits(MaxDigits)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_item_i  (item),
    .res_push_o (res_push),
    .res_o      (res),
    .res_full_i (res_full)
  );

  // output queue
  aifs_out_buf #(
    .Width($bits(res_t))
  ) u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .push_data_i (res),
    .full_o      (res_full),
    .valid_o     (m_axis_tvalid_o),
    .ready_i     (m_axis_tready_i),
    .data_o      (head_bits)
  );

  assign head = res_t'(head_bits);

  // pack result beat
  assign m_axis_tdata_o = {head.bytes_used, head.value};
  assign m_axis_tuser_o = {head.pushed_back, head.status};

endmodule

[design/aifs_out_buf.sv]
module aifs_out_buf #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [Width-1:0] data_o
);

  logic [1:0]       cnt_q, cnt_d;
  logic [Width-1:0] slot0_q, slot0_d;
  logic [Width-1:0] slot1_q, slot1_d;
  logic             pop;

  assign pop     = valid_o && ready_i;
  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = slot0_q;

  // two-entry queue, head always in slot0
  always_comb begin
    cnt_d   = cnt_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (push_i && !pop) begin
      if (cnt_q == 2'd0) begin
        slot0_d = push_data_i;
      end else begin
        slot1_d = push_data_i;
      end
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      slot0_d = slot1_q;
      cnt_d   = cnt_q - 2'd1;
    end else if (pop && push_i) begin
      if (cnt_q == 2'd1) begin
        slot0_d = push_data_i;
      end else begin
        slot0_d = slot1_q;
        slot1_d = push_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // payload slots
  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

[design/aifs_core.sv]
module aifs_core #(
  parameter int unsigned MaxDigits = aifs_pkg::MaxDigitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [7:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  aifs_pkg::item_t     in_item_i,
  output logic                res_push_o,
  output aifs_pkg::res_t      res_o,
  input  logic                res_full_i
);

  import aifs_pkg::*;

  localparam int unsigned CntW = $clog2(MaxDigits + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxDigits);

  typedef enum logic [3:0] {
    PH_SKIP   = 4'b0001,
    PH_SIGN   = 4'b0010,
    PH_PREFIX = 4'b0100,
    PH_DIGITS = 4'b1000
  } phase_e;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [5:0] NO_DIGIT = 6'd63;

  localparam logic [1:0] BASE_AUTO = 2'd0;
  localparam logic [1:0] BASE_OCT  = 2'd1;
  localparam logic [1:0] BASE_DEC  = 2'd2;
  localparam logic [1:0] BASE_HEX  = 2'd3;

  localparam logic [1:0] SIZE_8  = 2'd0;
  localparam logic [1:0] SIZE_16 = 2'd1;
  localparam logic [1:0] SIZE_32 = 2'd2;

  // digit value of a character, NO_DIGIT for anything else
  function automatic logic [5:0] digit_of(input logic [7:0] c);
    logic [5:0] d;
    d = NO_DIGIT;
    if (c inside {[8'h30:8'h39]}) begin
      d = 6'(c - 8'h30);
    end else if (c inside {[8'h61:8'h7A]}) begin
      d = 6'(c - 8'h61 + 8'd10);
    end else if (c inside {[8'h41:8'h5A]}) begin
      d = 6'(c - 8'h41 + 8'd10);
    end
    return d;
  endfunction

  function automatic logic [4:0] radix_of(input logic [1:0] b);
    logic [4:0] r;
    case (b)
      BASE_OCT: r = 5'd8;
      BASE_HEX: r = 5'd16;
      default:  r = 5'd10;
    endcase
    return r;
  endfunction

  // acc * base + digit, by shifts and adds
  function automatic logic [67:0] mul_add(input logic [63:0] acc, input logic [1:0] b,
                                          input logic [5:0] d);
    logic [67:0] a;
    logic [67:0] p;
    a = {4'b0, acc};
    case (b)
      BASE_OCT: p = a << 3;
      BASE_HEX: p = a << 4;
      default:  p = (a << 3) + (a << 1);
    endcase
    return p + {62'b0, d};
  endfunction

  // configuration registers
  logic [1:0] base_mode_q;
  logic [7:0] max_width_q;
  logic [1:0] out_size_q;
  logic       signed_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_mode_q  <= BASE_DEC;
      max_width_q  <= 8'd0;
      out_size_q   <= SIZE_32;
      signed_out_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BASE_MODE:  base_mode_q  <= cfg_data_i[1:0];
        REG_MAX_WIDTH:  max_width_q  <= cfg_data_i;
        REG_OUT_SIZE:   out_size_q   <= cfg_data_i[1:0];
        REG_SIGNED_OUT: signed_out_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input register
  logic       in_valid_q;
  item_t      in_q;
  logic       advance;

  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_item_i;
    end
  end

  // field state
  phase_e          phase_q, phase_d;
  logic [63:0]     acc_q, acc_d;
  logic            ovf_q, ovf_d;
  logic            neg_q, neg_d;
  logic            seen_q, seen_d;
  logic            wlim_q, wlim_d;
  logic [7:0]      wleft_q, wleft_d;
  logic [1:0]      abase_q, abase_d;
  logic [CntW-1:0] scnt_q, scnt_d;
  logic [15:0]     bcnt_q, bcnt_d;

  logic        fin;
  logic [1:0]  st;
  logic        pb;
  logic        take;
  logic        first;
  logic        dbyte;
  logic [7:0]  c;
  logic        e;
  logic [5:0]  dig;
  logic [67:0] prod;

  assign c   = in_q.in_byte;
  assign e   = in_q.at_end;
  assign dig = digit_of(c);

  // one byte of the conversion
  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    ovf_d   = ovf_q;
    neg_d   = neg_q;
    seen_d  = seen_q;
    wlim_d  = wlim_q;
    wleft_d = wleft_q;
    abase_d = abase_q;
    scnt_d  = scnt_q;
    fin     = 1'b0;
    st      = ST_OK;
    pb      = 1'b0;
    take    = 1'b0;
    first   = 1'b0;
    dbyte   = 1'b0;
    prod    = '0;

    case (phase_q)
      PH_SIGN: begin
        if (e) begin
          fin = 1'b1;
          st  = ST_MATCH_FAIL;
        end else begin
          first = 1'b1;
        end
      end
      PH_PREFIX: begin
        if (!e && (c == CH_X_LO || c == CH_X_UP)) begin
          take    = 1'b1;
          abase_d = BASE_HEX;
          if (scnt_d < CntMax) scnt_d = scnt_d + CntW'(1);
          if (scnt_d < CntMax) scnt_d = scnt_d + CntW'(1);
          wleft_d = (wleft_d > 8'd2) ? wleft_d - 8'd2 : 8'd0;
          phase_d = PH_DIGITS;
        end else begin
          // the leading zero counts as a digit of value zero
          if (abase_d == BASE_AUTO) abase_d = BASE_OCT;
          seen_d = 1'b1;
          if (scnt_d < CntMax) scnt_d = scnt_d + CntW'(1);
          wleft_d = (wleft_d > 8'd0) ? wleft_d - 8'd1 : 8'd0;
          if (e) begin
            fin = 1'b1;
            st  = ST_OK;
          end else begin
            phase_d = PH_DIGITS;
            dbyte   = 1'b1;
          end
        end
      end
      PH_DIGITS: begin
        if (e) begin
          fin = 1'b1;
          st  = seen_q ? ST_OK : ST_MATCH_FAIL;
        end else begin
          dbyte = 1'b1;
        end
      end
      default: begin
        if (e) begin
          fin = 1'b1;
          st  = ST_INPUT_FAIL;
        end else if (c == CH_SPACE || (c inside {[8'h09:8'h0D]})) begin
          take = 1'b1;
        end else begin
          abase_d = base_mode_q;
          wleft_d = max_width_q;
          wlim_d  = (max_width_q != 8'd0);
          if (c == CH_MINUS || c == CH_PLUS) begin
            take    = 1'b1;
            neg_d   = (c == CH_MINUS);
            scnt_d  = (c == CH_MINUS) ? CntW'(1) : '0;
            wleft_d = (wleft_d > 8'd0) ? wleft_d - 8'd1 : 8'd0;
            phase_d = PH_SIGN;
          end else begin
            first = 1'b1;
          end
        end
      end
    endcase

    // first byte after whitespace and sign
    if (first) begin
      if (c == CH_ZERO && (!wlim_d || wleft_d != 8'd0) &&
          (abase_d == BASE_AUTO || abase_d == BASE_HEX)) begin
        take    = 1'b1;
        seen_d  = 1'b1;
        phase_d = PH_PREFIX;
      end else begin
        if (abase_d == BASE_AUTO) abase_d = (c == CH_ZERO) ? BASE_OCT : BASE_DEC;
        phase_d = PH_DIGITS;
        dbyte   = 1'b1;
      end
    end

    // digit or stopping byte
    if (dbyte) begin
      if (wlim_d && wleft_d == 8'd0) begin
        fin = 1'b1;
        st  = seen_d ? ST_OK : ST_MATCH_FAIL;
        pb  = 1'b1;
      end else if (dig < {1'b0, radix_of(abase_d)}) begin
        take   = 1'b1;
        seen_d = 1'b1;
        if (scnt_d < CntMax) begin
          scnt_d = scnt_d + CntW'(1);
          if (!ovf_q) begin
            prod = mul_add(acc_q, abase_d, dig);
            if (prod[67:64] != 4'd0) begin
              ovf_d = 1'b1;
            end else begin
              acc_d = prod[63:0];
            end
          end
        end
        wleft_d = (wleft_d > 8'd0) ? wleft_d - 8'd1 : 8'd0;
      end else begin
        fin = 1'b1;
        st  = seen_d ? ST_OK : ST_MATCH_FAIL;
        pb  = 1'b1;
      end
    end

    bcnt_d = (take && bcnt_q != 16'hFFFF) ? bcnt_q + 16'd1 : bcnt_q;

    // field done: start over
    if (fin) begin
      phase_d = PH_SKIP;
      acc_d   = '0;
      ovf_d   = 1'b0;
      neg_d   = 1'b0;
      seen_d  = 1'b0;
      wlim_d  = 1'b0;
      wleft_d = '0;
      abase_d = BASE_AUTO;
      scnt_d  = '0;
      bcnt_d  = '0;
    end
  end

  assign advance    = in_valid_q && (!fin || !res_full_i);
  assign res_push_o = advance && fin;

  // result value from the state before this byte
  logic [63:0] mag;
  logic [63:0] ext;

  assign mag = ovf_q ? {64{1'b1}} : (neg_q ? 64'd0 - acc_q : acc_q);

  always_comb begin
    case (out_size_q)
      SIZE_8:  ext = {{56{signed_out_q & mag[7]}}, mag[7:0]};
      SIZE_16: ext = {{48{signed_out_q & mag[15]}}, mag[15:0]};
      SIZE_32: ext = {{32{signed_out_q & mag[31]}}, mag[31:0]};
      default: ext = mag;
    endcase
  end

  assign res_o.value       = (st == ST_OK) ? ext : 64'd0;
  assign res_o.status      = st;
  assign res_o.pushed_back = pb;
  assign res_o.bytes_used  = bcnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SKIP;
      acc_q   <= '0;
      ovf_q   <= 1'b0;
      neg_q   <= 1'b0;
      seen_q  <= 1'b0;
      wlim_q  <= 1'b0;
      wleft_q <= '0;
      abase_q <= BASE_AUTO;
      scnt_q  <= '0;
      bcnt_q  <= '0;
    end else if (advance) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      ovf_q   <= ovf_d;
      neg_q   <= neg_d;
      seen_q  <= seen_d;
      wlim_q  <= wlim_d;
      wleft_q <= wleft_d;
      abase_q <= abase_d;
      scnt_q  <= scnt_d;
      bcnt_q  <= bcnt_d;
    end
  end

endmodule

[test/ascii_integer_field_scanner_test.sv]
`timescale 1ns / 1ps

module ascii_integer_field_scanner_test;
  import aifs_pkg::*;

  // scanner phases of the prediction model
  typedef enum logic [1:0] {
    SCAN_SKIP,
    SCAN_SIGN,
    SCAN_PREFIX,
    SCAN_DIGITS
  } scan_phase_e;

  // base modes and result sizes
  localparam logic [1:0] BASE_AUTO = 2'd0;
  localparam logic [1:0] BASE_OCT  = 2'd1;
  localparam logic [1:0] BASE_DEC  = 2'd2;
  localparam logic [1:0] BASE_HEX  = 2'd3;
  localparam logic [1:0] SIZE_8    = 2'd0;
  localparam logic [1:0] SIZE_16   = 2'd1;
  localparam logic [1:0] SIZE_32   = 2'd2;
  localparam logic [1:0] SIZE_64   = 2'd3;

  localparam int unsigned DIGIT_SLOTS = MaxDigitsDefault;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned REPORT_CAP  = 200;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [7:0]  cfg_data_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;   // [7:0] in_byte
  logic [0:0]  s_axis_tuser_i = '0;   // [0] at_end
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [79:0] m_axis_tdata_o;        // [63:0] value, [79:64] bytes_used
  logic [2:0]  m_axis_tuser_o;        // [1:0] status, [2] pushed_back

  ascii_integer_field_scanner u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // text beats waiting to be sent and field results still to come
  item_t       pending_beats[$];
  res_t        expected_fields[$];
  item_t       next_beat;
  res_t        want;

  int unsigned cycle_cnt = 0;
  int unsigned stall_cycles = 0;
  int unsigned mismatch_count = 0;
  int unsigned beats_sent = 0;
  int unsigned fields_checked = 0;

  // register mirror
  logic [1:0]  cfg_base;
  logic [7:0]  cfg_width;
  logic [1:0]  cfg_size;
  logic        cfg_signed;

  // scanner state
  scan_phase_e scan_phase;
  logic [63:0] acc;
  logic        ovf, neg, seen, wlim;
  int unsigned wleft, nstored, nbytes;
  logic [1:0]  abase;

  // ---------------------------------------------------------------------------
  // field scanner prediction

  function automatic void clear_field();
    scan_phase = SCAN_SKIP;
    acc = '0;
    ovf = 1'b0;
    neg = 1'b0;
    seen = 1'b0;
    wlim = 1'b0;
    wleft = 0;
    abase = BASE_AUTO;
    nstored = 0;
    nbytes = 0;
  endfunction

  function automatic void take_byte();
    if (nbytes < 16'hFFFF) nbytes++;
  endfunction

  function automatic void use_width(int unsigned n);
    wleft = (wleft > n) ? wleft - n : 0;
  endfunction

  function automatic logic [4:0] radix();
    if (abase == BASE_OCT) return 5'd8;
    if (abase == BASE_HEX) return 5'd16;
    return 5'd10;
  endfunction

  function automatic void add_digit(logic [63:0] d);
    logic [63:0] b;
    b = 64'(radix());
    seen = 1'b1;
    if (nstored < DIGIT_SLOTS) begin
      nstored++;
      if (!ovf) begin
        if (acc > ({64{1'b1}} - d) / b) ovf = 1'b1;
        else acc = acc * b + d;
      end
    end
    use_width(1);
  endfunction

  // end of field: build the expected result and start over
  function automatic void close_field(logic [1:0] st, logic pb);
    logic [63:0] v, mask;
    int unsigned bits;
    res_t r;
    v = '0;
    if (st == ST_OK) begin
      bits = 8 << cfg_size;
      if (ovf) v = {64{1'b1}};
      else v = neg ? (64'd0 - acc) : acc;
      if (bits < 64) begin
        mask = (64'd1 << bits) - 64'd1;
        v &= mask;
        if (cfg_signed && v[bits-1]) v |= ~mask;
      end
    end
    r.value = v;
    r.status = st;
    r.pushed_back = pb;
    r.bytes_used = nbytes[15:0];
    expected_fields.push_back(r);
    clear_field();
  endfunction

  function automatic void digit_char(logic [7:0] c);
    int unsigned d;
    if (wlim && wleft == 0) begin
      close_field(seen ? ST_OK : ST_MATCH_FAIL, 1'b1);
      return;
    end
    if (c >= "0" && c <= "9") d = int'(c) - int'("0");
    else if (c >= "a" && c <= "z") d = int'(c) - int'("a") + 10;
    else if (c >= "A" && c <= "Z") d = int'(c) - int'("A") + 10;
    else d = 99;
    if (d < radix()) begin
      take_byte();
      add_digit(64'(d));
    end else begin
      close_field(seen ? ST_OK : ST_MATCH_FAIL, 1'b1);
    end
  endfunction

  // first byte after whitespace and sign
  function automatic void lead_char(logic [7:0] c);
    if (c == "0" && (!wlim || wleft != 0) && (abase == BASE_AUTO || abase == BASE_HEX)) begin
      take_byte();
      seen = 1'b1;
      scan_phase = SCAN_PREFIX;
    end else begin
      if (abase == BASE_AUTO) abase = (c == "0") ? BASE_OCT : BASE_DEC;
      scan_phase = SCAN_DIGITS;
      digit_char(c);
    end
  endfunction

  function automatic void scan_char(logic [7:0] c, logic at_end);
    case (scan_phase)
      SCAN_SIGN: begin
        if (at_end) close_field(ST_MATCH_FAIL, 1'b0);
        else lead_char(c);
      end
      SCAN_PREFIX: begin
        if (at_end) begin
          if (abase == BASE_AUTO) abase = BASE_OCT;
          add_digit(64'd0);
          close_field(ST_OK, 1'b0);
        end else if (c == "x" || c == "X") begin
          take_byte();
          abase = BASE_HEX;
          if (nstored < DIGIT_SLOTS) nstored++;
          if (nstored < DIGIT_SLOTS) nstored++;
          use_width(2);
          scan_phase = SCAN_DIGITS;
        end else begin
          if (abase == BASE_AUTO) abase = BASE_OCT;
          add_digit(64'd0);
          scan_phase = SCAN_DIGITS;
          digit_char(c);
        end
      end
      SCAN_DIGITS: begin
        if (at_end) close_field(seen ? ST_OK : ST_MATCH_FAIL, 1'b0);
        else digit_char(c);
      end
      default: begin
        if (at_end) begin
          close_field(ST_INPUT_FAIL, 1'b0);
        end else if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
          take_byte();
        end else begin
          abase = cfg_base;
          wleft = cfg_width;
          wlim = (cfg_width != 0);
          if (c == "-" || c == "+") begin
            take_byte();
            neg = (c == "-");
            nstored = neg ? 1 : 0;
            use_width(1);
            scan_phase = SCAN_SIGN;
          end else begin
            lead_char(c);
          end
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers

  function automatic void push_beat(logic [7:0] b, logic e);
    pending_beats.push_back(item_t'({e, b}));
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_beat(s[i], 1'b0);
  endfunction

  function automatic void push_end();
    push_beat(8'h00, 1'b1);
  endfunction

  // a mostly well-formed field for the current base, with random content
  function automatic void push_field();
    int unsigned r, n_dig, d;
    logic [4:0] rad;
    logic zeros;
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(1, 4)) push_beat(8'($urandom_range(255)), $urandom_range(7) == 0);
      return;
    end
    repeat ($urandom_range(0, 3)) begin
      r = $urandom_range(0, 5);
      push_beat(r == 0 ? 8'h20 : 8'(8 + r), 1'b0);
    end
    r = $urandom_range(0, 3);
    if (r == 0) push_text("+");
    else if (r == 1) push_text("-");
    rad = (cfg_base == BASE_OCT) ? 5'd8 : (cfg_base == BASE_HEX) ? 5'd16 : 5'd10;
    if (cfg_base == BASE_AUTO || cfg_base == BASE_HEX) begin
      r = $urandom_range(0, 3);
      if (r == 0) begin
        push_text("0x");
        rad = 5'd16;
      end else if (r == 1) begin
        push_text("0X");
        rad = 5'd16;
      end else if (r == 2 && cfg_base == BASE_AUTO) begin
        push_text("0");
        rad = 5'd8;
      end
    end
    r = $urandom_range(99);
    zeros = 1'b0;
    if (r < 2 && cfg_width == 0) begin
      n_dig = $urandom_range(250, 300);
      zeros = 1'b1;
    end else if (r < 22) begin
      n_dig = $urandom_range(13, 24);
    end else begin
      n_dig = $urandom_range(0, 12);
    end
    for (int i = 0; i < n_dig; i++) begin
      if (zeros && i + 3 < n_dig) d = 0;
      else if ($urandom_range(99) < 4) d = $urandom_range(0, 15);
      else d = $urandom_range(0, rad - 1);
      if (d < 10) push_beat(8'("0" + d), 1'b0);
      else if ($urandom_range(1) == 0) push_beat(8'("a" + d - 10), 1'b0);
      else push_beat(8'("A" + d - 10), 1'b0);
    end
    r = $urandom_range(0, 9);
    if (r <= 3) push_text(" ");
    else if (r <= 5) push_end();
    else if (r == 6) push_beat(8'($urandom_range(255)), 1'b0);
    else if (r == 7) push_text(",");
  endfunction

  // wait until everything sent has come back, then let the pipeline settle
  task automatic drain();
    do @(negedge clk_i);
    while (pending_beats.size() != 0 || s_axis_tvalid_i || expected_fields.size() != 0);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(logic [1:0] base, logic [7:0] width, logic [1:0] size,
                            logic sgn);
    drain();
    write_reg(REG_BASE_MODE, {6'd0, base});
    write_reg(REG_MAX_WIDTH, width);
    write_reg(REG_OUT_SIZE, {6'd0, size});
    write_reg(REG_SIGNED_OUT, {7'd0, sgn});
    cfg_base = base;
    cfg_width = width;
    cfg_size = size;
    cfg_signed = sgn;
  endtask

  function automatic void report_mismatch(string what, logic [63:0] exp_v, logic [63:0] act_v);
    mismatch_count++;
    if (mismatch_count <= REPORT_CAP)
      $display("%0t: %s mismatch: expected %h, actual %h", $realtime, what, exp_v, act_v);
  endfunction

  // ---------------------------------------------------------------------------
  // clock and reset

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  // ---------------------------------------------------------------------------
  // input driver: predicts each accepted beat, then loads the next one

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        scan_char(s_axis_tdata_i, s_axis_tuser_i[0]);
        beats_sent++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (pending_beats.size() != 0 &&
            !((cycle_cnt % 2000) < 1500 && $urandom_range(99) < 11)) begin
          next_beat = pending_beats.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i <= next_beat.in_byte;
          s_axis_tuser_i <= next_beat.at_end;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: compares each result beat with the oldest expected field

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_fields.size() == 0) begin
          report_mismatch("unexpected result, value", 64'd0, m_axis_tdata_o[63:0]);
        end else begin
          want = expected_fields.pop_front();
          fields_checked++;
          if (m_axis_tdata_o[63:0] !== want.value)
            report_mismatch("value", want.value, m_axis_tdata_o[63:0]);
          if (m_axis_tuser_o[1:0] !== want.status)
            report_mismatch("status", 64'(want.status), 64'(m_axis_tuser_o[1:0]));
          if (m_axis_tuser_o[2] !== want.pushed_back)
            report_mismatch("pushed_back", 64'(want.pushed_back), 64'(m_axis_tuser_o[2]));
          if (m_axis_tdata_o[79:64] !== want.bytes_used)
            report_mismatch("bytes_used", 64'(want.bytes_used), 64'(m_axis_tdata_o[79:64]));
        end
      end
      m_axis_tready_i <= !((cycle_cnt % 2000) < 1500 && $urandom_range(99) < 11);
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog on cycles with no beat moving on either side

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $realtime, STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus

  initial begin
    logic [7:0] width;
    int unsigned start_beats;
    cfg_base = BASE_DEC;
    cfg_width = 8'd0;
    cfg_size = SIZE_32;
    cfg_signed = 1'b1;
    clear_field();
    @(posedge rst_ni);

    // reset defaults: decimal, unlimited, 32-bit, sign-extended
    push_end();
    for (int k = 9; k <= 13; k++) push_beat(8'(k), 1'b0);
    push_text(" ");
    push_end();
    push_text("-");
    push_end();
    push_text("+x");
    push_text("2147483647 ");
    push_text("-2147483648 ");
    push_text("99999999999999999999999 ");
    push_beat(8'hC8, 1'b0);
    push_text("12");
    push_beat(8'hFF, 1'b0);
    // digits past the store do not count
    repeat (260) push_text("0");
    push_text("5");
    push_end();

    // auto base: prefixes, octal, overflow
    set_config(BASE_AUTO, 8'd0, SIZE_64, 1'b0);
    push_text("0x");
    push_end();
    push_text("0xg");
    push_text("017 ");
    push_text("0XfF ");
    push_text("-0x8000000000000000 ");
    push_text("0");
    push_end();
    push_text("08");
    push_text("0xFFFFFFFFFFFFFFFFF ");
    push_text("-18446744073709551615 ");

    // width of one: sign, prefix and digits all eat into it
    set_config(BASE_HEX, 8'd1, SIZE_8, 1'b1);
    push_text("+5");
    push_text("0x5");
    push_text("7f ");
    push_text("f");
    push_end();

    // widest limit, octal, 16-bit zero-extended
    set_config(BASE_OCT, 8'd255, SIZE_16, 1'b0);
    push_text("-1 ");
    push_text("778");
    push_text("3");
    push_end();

    // random phases over several settings
    for (int p = 0; p < 8; p++) begin
      width = 8'($urandom_range(4, 20));
      case (p)
        0: set_config(BASE_AUTO, 8'd0,   SIZE_64, 1'b0);
        1: set_config(BASE_OCT,  8'd255, SIZE_8,  1'b1);
        2: set_config(BASE_DEC,  8'd1,   SIZE_16, 1'b0);
        3: set_config(BASE_HEX,  8'd0,   SIZE_32, 1'b1);
        4: set_config(BASE_AUTO, 8'd3,   SIZE_8,  1'b0);
        5: set_config(BASE_HEX,  8'd2,   SIZE_64, 1'b1);
        6: set_config(BASE_DEC,  width,  SIZE_32, 1'b1);
        default: set_config(BASE_AUTO, 8'd0, SIZE_16, 1'b1);
      endcase
      start_beats = pending_beats.size();
      while (pending_beats.size() < start_beats + 190) push_field();
    end

    drain();
    $display("covered %0d input beats and %0d field results", beats_sent, fields_checked);
    $display("over all base modes, result sizes, both extensions and widths 0 to 255");
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
